/* rtl/tmr_pkg.sv */
`timescale 1ns / 1ps

package tmr_pkg;

  // Store geometry
  localparam int STORE_DEPTH = 16384;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Raster geometry; scrolled coordinates wrap at these sizes
  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 256;

  // Map layout, in map entries per tile row
  localparam int MAP_COLS_WIDE   = 80;
  localparam int MAP_COLS_NARROW = 40;

  // Attribute masks giving the palette offset
  localparam logic [7:0] PAL_MASK_TEXT   = 8'hFE;
  localparam logic [7:0] PAL_MASK_COLOUR = 8'hF0;

  // Queue between classifier and store sequencer
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Compare-subtract steps for the wrap reduction (quotient below 2**MOD_STEPS)
  localparam int MOD_W     = 12;
  localparam int MOD_STEPS = 4;

  // Request opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // Register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ATTR = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_BASE    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BASE = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_X    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_Y    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_WINDOW = 4'd7;

  // Register reset values
  localparam logic [5:0]  MAP_BASE_RESET     = 6'd44;
  localparam logic [5:0]  PATTERN_BASE_RESET = 6'd12;
  localparam logic [7:0]  TRANSPARENT_RESET  = 8'd15;
  localparam logic [31:0] CLIP_RESET         = 32'hFF009F00;

  typedef struct packed {
    logic        enable;
    logic        wide;
    logic        def_attr;
    logic        bank;
    logic        text;
    logic        tiles512;
    logic [7:0]  fallback_attr;
    logic [5:0]  map_base;
    logic [5:0]  pattern_base;
    logic [7:0]  transparent;
    logic [9:0]  scroll_x;
    logic [7:0]  scroll_y;
    logic [31:0] clip;
  } tmr_cfg_t;

  // Classified request as it travels through the queue
  typedef struct packed {
    logic              render;
    logic [ADDR_W-1:0] addr;     // store address, or map entry address
    logic [7:0]        data;
    logic              clipped;
    logic [2:0]        def_row;
    logic [2:0]        def_col;
  } tmr_item_t;

  typedef struct packed {
    logic       layer_enabled;
    logic       pixel_visible;
    logic       below_ula;
    logic       text_mode;
    logic       palette_bank;
    logic [7:0] colour_index;
  } tmr_result_t;

  // Remainder by a constant modulus through binary-weighted compare-subtract
  function automatic logic [MOD_W-1:0] wrap_mod(input logic [MOD_W-1:0] value,
                                                input logic [MOD_W-1:0] modulus);
    logic [MOD_W-1:0]           rem;
    logic [MOD_W+MOD_STEPS-1:0] step;
    rem = value;
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      step = {{MOD_STEPS{1'b0}}, modulus} << k;
      if ({{MOD_STEPS{1'b0}}, rem} >= step) begin
        rem = rem - step[MOD_W-1:0];
      end
    end
    return rem;
  endfunction

endpackage

/* rtl/tmr_queue.sv */
`timescale 1ns / 1ps

module tmr_queue
  import tmr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  tmr_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output tmr_item_t head
);

  tmr_item_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && full |-> pop)
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

/* rtl/tmr_front.sv */
`timescale 1ns / 1ps

module tmr_front
  import tmr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output tmr_cfg_t             cfg,
  // request channel
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 opcode,
  input  logic [ADDR_W-1:0]    store_address,
  input  logic [7:0]           store_data,
  input  logic [7:0]           raster_row,
  input  logic [9:0]           raster_column,
  // queue side
  output logic                 push,
  output tmr_item_t            push_item,
  input  logic                 queue_full
);

  // Stage one: scrolled and wrapped coordinates
  logic              s1_valid;
  logic              s1_render;
  logic [ADDR_W-1:0] s1_addr;
  logic [7:0]        s1_data;
  logic [7:0]        s1_row;
  logic [9:0]        s1_col;

  logic              accept;
  logic [MOD_W-1:0]  row_sum;
  logic [MOD_W-1:0]  col_sum;
  logic [MOD_W-1:0]  row_wrap;
  logic [MOD_W-1:0]  col_wrap;

  // Stage two: clip test and map address
  logic [7:0]        x1, x2, y1, y2;
  logic [7:0]        col_quad;
  logic [ADDR_W-1:0] map_cell;
  logic [ADDR_W-1:0] map_scaled;
  logic [ADDR_W-1:0] map_off;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable        <= 1'b0;
      cfg.wide          <= 1'b0;
      cfg.def_attr      <= 1'b0;
      cfg.bank          <= 1'b0;
      cfg.text          <= 1'b0;
      cfg.tiles512      <= 1'b0;
      cfg.fallback_attr <= '0;
      cfg.map_base      <= MAP_BASE_RESET;
      cfg.pattern_base  <= PATTERN_BASE_RESET;
      cfg.transparent   <= TRANSPARENT_RESET;
      cfg.scroll_x      <= '0;
      cfg.scroll_y      <= '0;
      cfg.clip          <= CLIP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CONTROL: begin
          cfg.enable   <= cfg_data[7];
          cfg.wide     <= cfg_data[6];
          cfg.def_attr <= cfg_data[5];
          cfg.bank     <= cfg_data[4];
          cfg.text     <= cfg_data[3];
          cfg.tiles512 <= cfg_data[1];
        end
        REG_DEFAULT_ATTR: cfg.fallback_attr     <= cfg_data[7:0];
        REG_MAP_BASE:     cfg.map_base          <= cfg_data[5:0];
        REG_PATTERN_BASE: cfg.pattern_base      <= cfg_data[5:0];
        REG_TRANSPARENT:  cfg.transparent       <= cfg_data[7:0];
        REG_SCROLL_X:     cfg.scroll_x          <= cfg_data[9:0];
        REG_SCROLL_Y:     cfg.scroll_y          <= cfg_data[7:0];
        REG_CLIP_WINDOW:  cfg.clip              <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: stage one holds while the queue is full
  assign push       = s1_valid && !queue_full;
  assign item_stall = s1_valid && queue_full;
  assign accept     = item_valid && !item_stall;

  // Scroll (doubled in 40-column mode) and wrap
  assign row_sum  = MOD_W'(raster_row) + MOD_W'(cfg.scroll_y);
  assign col_sum  = MOD_W'(raster_column)
                  + (cfg.wide ? MOD_W'(cfg.scroll_x) : MOD_W'({cfg.scroll_x, 1'b0}));
  assign row_wrap = wrap_mod(row_sum, MOD_W'(FRAME_HEIGHT));
  assign col_wrap = wrap_mod(col_sum, MOD_W'(FRAME_WIDTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_render <= (opcode == OP_RENDER);
      s1_addr   <= store_address;
      s1_data   <= store_data;
      s1_row    <= row_wrap[7:0];
      s1_col    <= col_wrap[9:0];
    end
  end

  // Clip window, columns in units of four
  assign x1       = cfg.clip[7:0];
  assign x2       = cfg.clip[15:8];
  assign y1       = cfg.clip[23:16];
  assign y2       = cfg.clip[31:24];
  assign col_quad = s1_col[9:2];

  // Map entry address, two bytes per entry unless the default attribute is used
  assign map_cell   = ADDR_W'(s1_row[7:3])
                    * (cfg.wide ? ADDR_W'(MAP_COLS_WIDE) : ADDR_W'(MAP_COLS_NARROW))
                    + (cfg.wide ? ADDR_W'(s1_col[9:3]) : ADDR_W'(s1_col[9:4]));
  assign map_scaled = cfg.def_attr ? map_cell : {map_cell[ADDR_W-2:0], 1'b0};
  assign map_off    = {cfg.map_base, 8'd0} + map_scaled;

  always_comb begin
    push_item         = '0;
    push_item.render  = s1_render;
    push_item.data    = s1_data;
    push_item.addr    = s1_render ? map_off : s1_addr;
    push_item.clipped = (s1_row < y1) || (s1_row > y2) || (col_quad < x1) || (col_quad > x2);
    push_item.def_row = s1_row[2:0];
    push_item.def_col = cfg.wide ? s1_col[2:0] : s1_col[3:1];
  end

endmodule

/* rtl/tmr_back.sv */
`timescale 1ns / 1ps

module tmr_back
  import tmr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  tmr_cfg_t    cfg,
  // queue side
  input  logic        head_valid,
  input  tmr_item_t   head,
  output logic        pop,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output tmr_result_t result
);

  typedef enum logic [1:0] {
    SEQ_MAP = 2'b01,
    SEQ_DEF = 2'b10
  } seq_t;

  seq_t seq, seq_next;

  // Video store with one write and two read ports
  logic [7:0]        store [STORE_DEPTH];
  logic              wr_en;
  logic              rd_a_en, rd_b_en;
  logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;
  logic [7:0]        rd_a, rd_b;

  // Definition read in flight
  logic              p2_valid;
  logic              p2_load;
  logic              p2_adv;
  logic              p2_free;
  logic [7:0]        p2_attr;
  logic [2:0]        p2_def_col;
  logic              p2_clipped;

  logic [7:0]        attr_sel;
  logic [8:0]        tile;
  logic [ADDR_W-1:0] def_rel;
  logic [ADDR_W-1:0] def_off;

  logic [7:0]        pattern;
  logic [3:0]        pix;
  logic [7:0]        pal_off;
  tmr_result_t       finished;

  assign p2_adv  = p2_valid && (!result_valid || !result_stall);
  assign p2_free = !p2_valid || p2_adv;

  // Attribute and tile from the map read, then the definition address
  assign attr_sel = cfg.def_attr ? cfg.fallback_attr : rd_b;
  assign tile     = {cfg.tiles512 & attr_sel[0], rd_a};
  assign def_rel  = cfg.text
                  ? ADDR_W'({tile, 3'd0}) + ADDR_W'(head.def_row)
                  : ADDR_W'({tile, 5'd0}) + ADDR_W'({head.def_row, 2'b00})
                    + ADDR_W'(head.def_col[2:1]);
  assign def_off  = {cfg.pattern_base, 8'd0} + def_rel;

  // Sequencer: map read, then definition read; writes complete in the map phase
  always_comb begin
    seq_next  = seq;
    pop       = 1'b0;
    wr_en     = 1'b0;
    rd_a_en   = 1'b0;
    rd_b_en   = 1'b0;
    rd_a_addr = head.addr;
    rd_b_addr = head.addr + 1'b1;
    p2_load   = 1'b0;
    case (seq)
      SEQ_MAP: begin
        if (head_valid && !head.render) begin
          wr_en = 1'b1;
          pop   = 1'b1;
        end else if (head_valid && p2_free) begin
          rd_a_en  = 1'b1;
          rd_b_en  = 1'b1;
          seq_next = SEQ_DEF;
        end
      end
      SEQ_DEF: begin
        rd_a_en   = 1'b1;
        rd_a_addr = def_off;
        p2_load   = 1'b1;
        pop       = 1'b1;
        seq_next  = SEQ_MAP;
      end
      default: seq_next = SEQ_MAP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) seq <= SEQ_MAP;
    else     seq <= seq_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en)   store[head.addr] <= head.data;
    if (rd_a_en) rd_a <= store[rd_a_addr];
    if (rd_b_en) rd_b <= store[rd_b_addr];
  end

  // Definition stage bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (p2_load) begin
      p2_valid <= 1'b1;
    end else if (p2_adv) begin
      p2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_load) begin
      p2_attr    <= attr_sel;
      p2_def_col <= head.def_col;
      p2_clipped <= head.clipped;
    end
  end

  // Pixel from the definition byte
  assign pattern = rd_a;
  assign pal_off = p2_attr & (cfg.text ? PAL_MASK_TEXT : PAL_MASK_COLOUR);

  always_comb begin
    if (cfg.text)           pix = {3'd0, pattern[3'd7 - p2_def_col]};
    else if (p2_def_col[0]) pix = pattern[3:0];
    else                    pix = pattern[7:4];
  end

  always_comb begin
    finished = '0;
    if (cfg.enable) begin
      finished.layer_enabled = 1'b1;
      finished.pixel_visible = !p2_clipped && ({4'd0, pix} != cfg.transparent);
      finished.below_ula     = !cfg.tiles512 && p2_attr[0];
      finished.text_mode     = cfg.text;
      finished.palette_bank  = cfg.bank;
      finished.colour_index  = pal_off | {4'd0, pix};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (p2_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_adv) result <= finished;
  end

  a_def_follows_map: assert property (@(posedge clk) disable iff (rst)
    seq == SEQ_DEF |=> seq == SEQ_MAP)
    else $error("definition read not followed by map phase");

  a_def_slot_free: assert property (@(posedge clk) disable iff (rst)
    seq == SEQ_DEF |-> !p2_valid)
    else $error("definition read issued over a pending one");

  a_def_render_head: assert property (@(posedge clk) disable iff (rst)
    seq == SEQ_DEF |-> head_valid && head.render)
    else $error("definition phase without a pixel request at the head");

  a_map_read_guard: assert property (@(posedge clk) disable iff (rst)
    rd_b_en |-> p2_free)
    else $error("map read would overwrite pending definition data");

endmodule

/* rtl/tilemap_pixel_renderer.sv */
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// request   item_valid/item_stall opcode, store_address, store_data,
//                                 raster_row, raster_column
// result    result_valid/         layer_enabled, pixel_visible, below_ula,
//           result_stall          text_mode, palette_bank, colour_index
// config    cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A pixel request holds the store sequencer for a map entry and attribute
// read, then the dependent definition read; a store write only for its write.
// The classifier takes one request a cycle into a 4-entry queue while it has
// room. When idle, result_valid follows stage one, the queue, the store reads
// and the output register. Synchronous reset clears control state and loads
// register defaults; the store itself is not cleared. A stalled result keeps
// the pipe moving until the queue fills, then item_stall rises.

module tilemap_pixel_renderer
  import tmr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  // requests
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 opcode,
  input  logic [ADDR_W-1:0]    store_address,
  input  logic [7:0]           store_data,
  input  logic [7:0]           raster_row,
  input  logic [9:0]           raster_column,
  // results
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 layer_enabled,
  output logic                 pixel_visible,
  output logic                 below_ula,
  output logic                 text_mode,
  output logic                 palette_bank,
  output logic [7:0]           colour_index
);

  tmr_cfg_t    cfg;
  logic        push;
  tmr_item_t   push_item;
  logic        queue_full;
  logic        pop;
  logic        head_valid;
  tmr_item_t   head;
  tmr_result_t result;

  // Registers always take a write
  assign cfg_ready = 1'b1;

  tmr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cfg           (cfg),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .opcode        (opcode),
    .store_address (store_address),
    .store_data    (store_data),
    .raster_row    (raster_row),
    .raster_column (raster_column),
    .push          (push),
    .push_item     (push_item),
    .queue_full    (queue_full)
  );

  tmr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  tmr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign layer_enabled = result.layer_enabled;
  assign pixel_visible = result.pixel_visible;
  assign below_ula     = result.below_ula;
  assign text_mode     = result.text_mode;
  assign palette_bank  = result.palette_bank;
  assign colour_index  = result.colour_index;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import tmr_pkg::*;

  // Register indexes beyond the defined set; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;
  localparam int ADDR_MASK = STORE_DEPTH - 1;

  // Shadow of the renderer: store contents, registers and pending pixels
  class pixel_scoreboard;
    bit [7:0]    video_copy [STORE_DEPTH];
    bit          written [STORE_DEPTH];
    bit [7:0]    ctrl = '0;
    bit [7:0]    dflt_attr = '0;
    bit [5:0]    map_page = MAP_BASE_RESET;
    bit [5:0]    pat_page = PATTERN_BASE_RESET;
    bit [7:0]    transp = TRANSPARENT_RESET;
    bit [9:0]    scroll_x_r = '0;
    bit [7:0]    scroll_y_r = '0;
    bit [31:0]   clip = CLIP_RESET;
    tmr_result_t expected_pixels [$];
    int          faults = 0;

    function void set_register(bit [CFG_IDX_W-1:0] idx, bit [31:0] v);
      case (idx)
        REG_CONTROL:      ctrl = v[7:0];
        REG_DEFAULT_ATTR: dflt_attr = v[7:0];
        REG_MAP_BASE:     map_page = v[5:0];
        REG_PATTERN_BASE: pat_page = v[5:0];
        REG_TRANSPARENT:  transp = v[7:0];
        REG_SCROLL_X:     scroll_x_r = v[9:0];
        REG_SCROLL_Y:     scroll_y_r = v[7:0];
        REG_CLIP_WINDOW:  clip = v;
        default: ;
      endcase
    endfunction

    // Works out one pixel and the map and definition addresses it reads
    function tmr_result_t predict_pixel(bit [7:0] row, bit [9:0] col,
                                        output int map_a, output int def_a);
      int r, c, x1, x2, y1, y2, attr, tile, drow, dcol, pat, pal, pix;
      bit wide, da, text, t512, clipped;
      tmr_result_t res;
      wide = ctrl[6];
      da   = ctrl[5];
      text = ctrl[3];
      t512 = ctrl[1];
      r = (int'(row) + int'(scroll_y_r)) % FRAME_HEIGHT;
      c = (int'(col) + int'(scroll_x_r) * (wide ? 1 : 2)) % FRAME_WIDTH;
      x1 = int'(clip[7:0]);
      x2 = int'(clip[15:8]);
      y1 = int'(clip[23:16]);
      y2 = int'(clip[31:24]);
      clipped = (r < y1) || (r > y2) || (c / 4 < x1) || (c / 4 > x2);
      // map entry is one byte with a default attribute, else tile then attribute
      map_a = (int'(map_page) << 8)
            + ((r / 8) * (wide ? MAP_COLS_WIDE : MAP_COLS_NARROW) + c / (wide ? 8 : 16))
              * (da ? 1 : 2);
      map_a = map_a & ADDR_MASK;
      attr = da ? int'(dflt_attr) : int'(video_copy[(map_a + 1) & ADDR_MASK]);
      tile = int'(video_copy[map_a]) | (t512 ? ((attr & 1) << 8) : 0);
      drow = r % 8;
      dcol = (c / (wide ? 1 : 2)) % 8;
      if (text) begin
        def_a = (int'(pat_page) << 8) + tile * 8 + drow;
      end else begin
        def_a = (int'(pat_page) << 8) + tile * 32 + drow * 4 + dcol / 2;
      end
      def_a = def_a & ADDR_MASK;
      pat = int'(video_copy[def_a]);
      pal = attr & int'(text ? PAL_MASK_TEXT : PAL_MASK_COLOUR);
      if (text) begin
        pix = (pat >> (7 - dcol)) & 1;
      end else begin
        pix = (dcol % 2 != 0) ? (pat & 15) : (pat >> 4);
      end
      res = '0;
      if (ctrl[7]) begin
        res.layer_enabled = 1'b1;
        res.pixel_visible = !(clipped || pix == int'(transp));
        res.below_ula     = t512 ? 1'b0 : attr[0];
        res.text_mode     = text;
        res.palette_bank  = ctrl[4];
        res.colour_index  = 8'(pal | pix);
      end
      return res;
    endfunction

    // First store entry this pixel would read that has never been written
    function int missing_entry(bit [7:0] row, bit [9:0] col);
      int map_a, def_a;
      tmr_result_t ignored;
      ignored = predict_pixel(row, col, map_a, def_a);
      if (!written[map_a]) return map_a;
      if (!written[(map_a + 1) & ADDR_MASK]) return (map_a + 1) & ADDR_MASK;
      if (!written[def_a]) return def_a;
      return -1;
    endfunction

    function void note_request(bit op, bit [ADDR_W-1:0] addr, bit [7:0] data,
                               bit [7:0] row, bit [9:0] col);
      int map_a, def_a;
      if (op == OP_WRITE) begin
        video_copy[addr] = data;
        written[addr] = 1'b1;
      end else begin
        expected_pixels.push_back(predict_pixel(row, col, map_a, def_a));
      end
    endfunction

    function void compare(string name, logic [7:0] exp_v, logic [7:0] got_v);
      if (got_v !== exp_v) begin
        faults++;
        $display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(tmr_result_t got);
      tmr_result_t exp_r;
      if (expected_pixels.size() == 0) begin
        faults++;
        $display("%0t: pixel result with none pending, got %0h", $time, got);
        return;
      end
      exp_r = expected_pixels.pop_front();
      compare("layer_enabled", 8'(exp_r.layer_enabled), 8'(got.layer_enabled));
      compare("pixel_visible", 8'(exp_r.pixel_visible), 8'(got.pixel_visible));
      compare("below_ula", 8'(exp_r.below_ula), 8'(got.below_ula));
      compare("text_mode", 8'(exp_r.text_mode), 8'(got.text_mode));
      compare("palette_bank", 8'(exp_r.palette_bank), 8'(got.palette_bank));
      compare("colour_index", exp_r.colour_index, got.colour_index);
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 item_valid;
  logic                 item_stall;
  logic                 opcode;
  logic [ADDR_W-1:0]    store_address;
  logic [7:0]           store_data;
  logic [7:0]           raster_row;
  logic [9:0]           raster_column;
  logic                 result_valid;
  logic                 result_stall;
  logic                 layer_enabled;
  logic                 pixel_visible;
  logic                 below_ula;
  logic                 text_mode;
  logic                 palette_bank;
  logic [7:0]           colour_index;

  pixel_scoreboard board;
  bit tx_lazy = 1'b1;
  bit rx_lazy = 1'b1;
  int sent = 0;

  tilemap_pixel_renderer dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall time limit
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // One request: optional idle gap, then hold until accepted
  task automatic send_request(bit op, bit [ADDR_W-1:0] addr, bit [7:0] data,
                              bit [7:0] row, bit [9:0] col);
    int gap;
    gap = tx_lazy ? $urandom_range(0, 17) : 0;
    repeat (gap) begin
      @(negedge clk);
      item_valid = 1'b0;
    end
    @(negedge clk);
    item_valid    = 1'b1;
    opcode        = op;
    store_address = addr;
    store_data    = data;
    raster_row    = row;
    raster_column = col;
    do @(posedge clk); while (item_stall);
    board.note_request(op, addr, data, row, col);
    sent++;
  endtask

  // Pixel request, preceded by writes to any store entry it would read unwritten
  task automatic send_pixel(bit [7:0] row, bit [9:0] col);
    int a;
    a = board.missing_entry(row, col);
    while (a >= 0) begin
      send_request(OP_WRITE, a[ADDR_W-1:0], 8'($urandom), 8'($urandom), 10'($urandom));
      a = board.missing_entry(row, col);
    end
    send_request(OP_RENDER, ADDR_W'($urandom), 8'($urandom), row, col);
  endtask

  task automatic write_register(bit [CFG_IDX_W-1:0] idx, bit [31:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    board.set_register(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Junk above the register width, which the block must ignore
  function automatic bit [31:0] pad(int w, bit [31:0] v);
    return (32'($urandom) << w) | v;
  endfunction

  task automatic apply_settings(bit [7:0] ctl, bit [7:0] dattr, bit [5:0] mp, bit [5:0] pp,
                                bit [7:0] tr, bit [9:0] sx, bit [7:0] sy, bit [31:0] cw);
    write_register(REG_CONTROL, pad(8, ctl));
    write_register(REG_DEFAULT_ATTR, pad(8, dattr));
    write_register(REG_MAP_BASE, pad(6, mp));
    write_register(REG_PATTERN_BASE, pad(6, pp));
    write_register(REG_TRANSPARENT, pad(8, tr));
    write_register(REG_SCROLL_X, pad(10, sx));
    write_register(REG_SCROLL_Y, pad(8, sy));
    write_register(REG_CLIP_WINDOW, cw);
    write_register(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
  endtask

  // Stop offering, let every pending pixel come back, then allow the pipe to empty
  task automatic settle();
    @(negedge clk);
    item_valid = 1'b0;
    while (board.expected_pixels.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Random requests until the running request count reaches the target
  task automatic run_random(int target);
    while (sent < target) begin
      if ($urandom_range(0, 39) == 0) tx_lazy = !tx_lazy;
      if ($urandom_range(0, 9) < 3) begin
        send_request(OP_WRITE, ADDR_W'($urandom), 8'($urandom), 8'($urandom),
                     10'($urandom));
      end else begin
        send_pixel(8'($urandom), ($urandom_range(0, 15) == 0)
                                 ? 10'($urandom_range(640, 1023))
                                 : 10'($urandom_range(0, 639)));
      end
    end
  endtask

  // Result side: random stalls, two long hold-offs to back the block up
  initial begin
    int hold;
    int taken;
    tmr_result_t got;
    hold = 0;
    taken = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      result_stall = (hold > 0);
      if (hold > 0) hold--;
      @(posedge clk);
      if (result_valid && !result_stall && !rst) begin
        got.layer_enabled = layer_enabled;
        got.pixel_visible = pixel_visible;
        got.below_ula     = below_ula;
        got.text_mode     = text_mode;
        got.palette_bank  = palette_bank;
        got.colour_index  = colour_index;
        board.check_result(got);
        taken++;
        if ($urandom_range(0, 39) == 0) rx_lazy = !rx_lazy;
        hold = rx_lazy ? $urandom_range(0, 17) : 0;
        if (taken == 40 || taken == 160) hold = 400;
      end
    end
  end

  // Main sequence
  initial begin
    bit [7:0]  ctl;
    bit [7:0]  tr;
    bit [31:0] cw;
    board = new();
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    item_valid    = 1'b0;
    opcode        = OP_WRITE;
    store_address = '0;
    store_data    = '0;
    raster_row    = '0;
    raster_column = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // register defaults, layer off; store extremes
    send_request(OP_WRITE, '0, 8'h00, 8'h00, 10'h000);
    send_request(OP_WRITE, '1, 8'hFF, 8'hFF, 10'h3FF);
    send_pixel(8'd0, 10'd0);
    send_pixel(8'd255, 10'd639);
    settle();

    // plain 40-column colour mode, columns past the frame edge
    apply_settings(8'h80, 8'h00, MAP_BASE_RESET, PATTERN_BASE_RESET, TRANSPARENT_RESET,
                   10'd0, 8'd0, CLIP_RESET);
    send_pixel(8'd0, 10'd0);
    send_pixel(8'd255, 10'd639);
    send_pixel(8'd255, 10'd0);
    send_pixel(8'd0, 10'd639);
    send_pixel(8'd130, 10'd1023);
    send_pixel(8'd7, 10'd640);
    settle();

    // every mode bit set, top pages and largest scroll so addresses wrap
    apply_settings(8'hFF, 8'hFF, 6'd63, 6'd63, 8'h01, 10'h3FF, 8'hFF, 32'hFF00FF00);
    send_pixel(8'd0, 10'd0);
    send_pixel(8'd255, 10'd1023);
    send_pixel(8'd200, 10'd639);
    send_pixel(8'd1, 10'd1);
    settle();

    // zero bases, scroll and clip: single-cell clip window, text with default attribute
    apply_settings(8'hB8, 8'h5A, 6'd0, 6'd0, 8'h00, 10'd0, 8'd0, 32'h0000_0000);
    send_pixel(8'd0, 10'd0);
    send_pixel(8'd0, 10'd3);
    send_pixel(8'd1, 10'd0);
    settle();

    // inverted clip windows, horizontal then vertical
    apply_settings(8'hC0, 8'h00, 6'd20, 6'd40, 8'd15, 10'd3, 8'd9, 32'hFF00_1020);
    send_pixel(8'd10, 10'd100);
    send_pixel(8'd200, 10'd400);
    settle();
    apply_settings(8'h80, 8'h00, 6'd20, 6'd40, 8'd15, 10'd3, 8'd9, 32'h1020_FF00);
    send_pixel(8'd15, 10'd50);
    send_pixel(8'd30, 10'd600);
    settle();

    // random settings, each followed by a burst of random requests
    for (int p = 0; p < 10; p++) begin
      ctl = 8'($urandom);
      if ($urandom_range(0, 9) != 0) ctl[7] = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        tr = 8'($urandom);
      end else begin
        tr = 8'($urandom_range(0, ctl[3] ? 1 : 15));
      end
      if ($urandom_range(0, 3) == 0) begin
        cw = $urandom;
      end else begin
        cw = {8'($urandom_range(160, 255)), 8'($urandom_range(0, 60)),
              8'($urandom_range(100, 255)), 8'($urandom_range(0, 40))};
      end
      apply_settings(ctl, 8'($urandom), 6'($urandom), 6'($urandom), tr, 10'($urandom),
                     8'($urandom), cw);
      run_random((p + 1) * 140);
      settle();
    end

    repeat (20) @(posedge clk);
    if (board.faults == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
